>>> rtl/core/lbp_pkg.sv
// Shared constants and types of the 3x3 local binary pattern unit.
// No dependencies; the two interfaces, the unit and the testbench import this package.
package lbp_pkg;

  // field widths of the pixel and result words
  localparam int PIXEL_W = 8;
  localparam int CODE_W  = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;

  // configuration register widths and codes
  localparam int IMG_W_BITS  = 11;
  localparam int IMG_H_BITS  = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd480;

  // geometry limits
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MIN_DIM       = 3;
  localparam int MAX_HEIGHT    = 4096;

  // one result word
  typedef struct packed {
    logic [CODE_W-1:0] pattern_code;
    logic [COL_W-1:0]  center_col;
    logic [ROW_W-1:0]  center_row;
    logic              frame_last;
  } lbp_result_t;

endpackage

>>> rtl/core/lbp_pixel_if.sv
// Pixel stream channel: valid/ready handshake with one grey pixel per word.
// Depends on lbp_pkg for the pixel width.
interface lbp_pixel_if import lbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

>>> rtl/core/lbp_result_if.sv
// Result stream channel: valid/ready handshake carrying one pattern word.
// Depends on lbp_pkg for the lbp_result_t payload type.
interface lbp_result_if import lbp_pkg::*; ();
  logic        valid;
  logic        ready;
  lbp_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/lbp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/local_binary_pattern_3x3_unit.sv
// 3x3 local binary pattern unit over a raster pixel stream.
// A window's last pixel is registered; its result word then goes into the output queue.
// Throughput: one pixel per cycle with queue room; line stores: one read, one write per cycle.
// Reset (synchronous, rst high): counters, window, output queue cleared; size back to 640x480.
// The two line stores are not cleared; they are only read for real results once written.
module local_binary_pattern_3x3_unit import lbp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lbp_pixel_if.sink              pixels,
  lbp_result_if.source           results
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = ($clog2(MAX_WIDTH + 1) > IMG_W_BITS) ? $clog2(MAX_WIDTH + 1) : IMG_W_BITS;

  // word in flight while the line stores are read
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [CW-1:0]      col;
    logic [ROW_W-1:0]   row;
    logic [PIXEL_W-1:0] pixel;
  } stage_t;

  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;

  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;

  logic   s1_valid;
  stage_t s1;

  logic [PIXEL_W-1:0] window_regs [9];
  logic [PIXEL_W-1:0] up_rd;
  logic [PIXEL_W-1:0] mid_rd;

  lbp_result_t q_mem [2];
  logic        q_wr_ptr;
  logic        q_rd_ptr;
  logic [1:0]  q_count;

  logic              accept;
  logic              pop;
  logic [1:0]        occupancy;
  logic [EW-1:0]     w_ext;
  logic [EW-1:0]     w_eff;
  logic [IMG_H_BITS-1:0] h_eff;
  logic              row_end;
  logic              frame_end;
  logic              emit_now;
  logic              push;
  lbp_result_t       res_new;
  logic [CODE_W-1:0] code;
  logic [PIXEL_W-1:0] centre;
  logic [PIXEL_W-1:0] nb [8];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, saturated into the legal range
  always_comb begin
    w_ext = EW'(image_width);
    if (w_ext < EW'(MIN_DIM)) begin
      w_eff = EW'(MIN_DIM);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (image_height < IMG_H_BITS'(MIN_DIM)) begin
      h_eff = IMG_H_BITS'(MIN_DIM);
    end else if (image_height > IMG_H_BITS'(MAX_HEIGHT)) begin
      h_eff = IMG_H_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  assign row_end   = EW'(col_count) >= (w_eff - EW'(1));
  assign frame_end = row_end && ({1'b0, row_count} >= (h_eff - IMG_H_BITS'(1)));
  assign emit_now  = (col_count >= CW'(2)) && (row_count >= ROW_W'(2));

  // input ready: room in the queue for the word in flight plus a new one
  assign pop       = results.valid && results.ready;
  assign occupancy = q_count + {1'b0, s1_valid};
  assign pixels.ready = !rst && ((occupancy < 2'd2) || ((occupancy == 2'd2) && pop));
  assign accept    = pixels.valid && pixels.ready;

  // column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= frame_end ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // stage 1: line store read outstanding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.emit  <= emit_now;
      s1.last  <= frame_end;
      s1.col   <= col_count;
      s1.row   <= row_count;
      s1.pixel <= pixels.pixel;
    end
  end

  // line stores: read at accept, written back from stage 1 in the next cycle (rows shift up)
  lbp_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.col),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (col_count),
    .rdata (up_rd)
  );

  lbp_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_middle (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.col),
    .wdata (s1.pixel),
    .re    (accept),
    .raddr (col_count),
    .rdata (mid_rd)
  );

  // window shift: columns move west, new column enters on the east
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window_regs[i] <= '0;
      end
    end else if (s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        window_regs[i*3]   <= window_regs[i*3+1];
        window_regs[i*3+1] <= window_regs[i*3+2];
      end
      window_regs[2] <= up_rd;
      window_regs[5] <= mid_rd;
      window_regs[8] <= s1.pixel;
    end
  end

  // neighbors of the shifted window, taken before it is registered
  always_comb begin
    centre = window_regs[5];
    nb[0]  = mid_rd;          // east
    nb[1]  = up_rd;           // north-east
    nb[2]  = window_regs[2];  // north
    nb[3]  = window_regs[1];  // north-west
    nb[4]  = window_regs[4];  // west
    nb[5]  = window_regs[7];  // south-west
    nb[6]  = window_regs[8];  // south
    nb[7]  = s1.pixel;        // south-east
    for (int n = 0; n < 8; n++) begin
      code[n] = nb[n] >= centre;
    end
  end

  assign push = s1_valid && s1.emit;

  always_comb begin
    res_new.pattern_code = code;
    res_new.center_col   = COL_W'(s1.col - CW'(1));
    res_new.center_row   = s1.row - ROW_W'(1);
    res_new.frame_last   = s1.last;
  end

  // two-word output queue
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= 1'b0;
      q_rd_ptr <= 1'b0;
      q_count  <= '0;
    end else begin
      if (push) begin
        q_wr_ptr <= ~q_wr_ptr;
      end
      if (pop) begin
        q_rd_ptr <= ~q_rd_ptr;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign results.valid = q_count != 2'd0;
  assign results.data  = q_mem[q_rd_ptr];

endmodule

>>> tb/tb_local_binary_pattern_3x3_unit.sv
// Self-checking testbench of the 3x3 local binary pattern unit: writes the size registers, drives pixel words,
// predicts or takes from its table every pattern word and compares it field by field as it leaves the block.
// Depends on lbp_pkg, lbp_pixel_if, lbp_result_if and local_binary_pattern_3x3_unit.
module tb_local_binary_pattern_3x3_unit;
  import lbp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 50;

  typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_e;
  typedef enum int {TEX_NOISE, TEX_TIES, TEX_EXTREME, TEX_FLAT} texture_e;

  // one row of the directed table; value holds the register data or the pixel
  typedef struct packed {
    step_kind_e             kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  value;
    logic                   typed;
    lbp_result_t            want;
  } directed_step_t;

  localparam lbp_result_t NO_WORD = '0;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lbp_pixel_if  pix_ch ();
  lbp_result_if res_ch ();

  local_binary_pattern_3x3_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .results   (res_ch)
  );

  // predictor state: line stores, window, raster counters, size registers
  logic [PIXEL_W-1:0]    upper_line  [0:MAX_WIDTH_DEF-1];
  logic [PIXEL_W-1:0]    middle_line [0:MAX_WIDTH_DEF-1];
  logic [PIXEL_W-1:0]    win [0:8];
  logic [COL_W-1:0]      col_pos    = '0;
  logic [ROW_W-1:0]      row_pos    = '0;
  logic [IMG_W_BITS-1:0] width_reg  = IMAGE_WIDTH_RESET;
  logic [IMG_H_BITS-1:0] height_reg = IMAGE_HEIGHT_RESET;
  // line store columns written at least once / twice since reset (always a prefix)
  int unsigned           cols_written_once  = 0;
  int unsigned           cols_written_twice = 0;

  lbp_result_t           expected_patterns [$];
  int unsigned           mismatch_count = 0;
  bit                    steady   = 1'b0;   // no random idling on either side
  int unsigned           hold_requests = 0; // each one asks the receiver for a long hold-off

  // 3x3 size through out-of-range registers, then three frames with known codes
  directed_step_t directed_steps [29] = '{
    '{STEP_WRITE, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_WRITE, REG_IMAGE_HEIGHT, 13'd1,   1'b0, NO_WORD},
    // bright centre on black: no neighbour reaches it
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b1, '{8'h00, 10'd1, 12'd1, 1'b1}},
    // black centre on white: every neighbour counts
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b1, '{8'hFF, 10'd1, 12'd1, 1'b1}},
    // centre 100, neighbours above, below and equal: E, NE, NW, S, SE set
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd100, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd99,  1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd101, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,   1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd100, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd255, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd99,  1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd100, 1'b0, NO_WORD},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd101, 1'b1, '{8'hCB, 10'd1, 12'd1, 1'b1}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // effective row length: the width register saturated into the legal range
  function automatic int unsigned span_cols(input logic [IMG_W_BITS-1:0] raw);
    if (raw < MIN_DIM) return MIN_DIM;
    if (raw > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return 32'(raw);
  endfunction

  // advance the predictor by one pixel; returns 1 when a pattern word results
  function automatic bit lbp_advance(input logic [PIXEL_W-1:0] px, output lbp_result_t res);
    int unsigned        w, h, c, r, k;
    logic [PIXEL_W-1:0] up, mid, ctr;
    bit                 row_done, frame_done, emits;
    w = span_cols(width_reg);
    h = (height_reg < MIN_DIM) ? MIN_DIM : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    c = 32'(col_pos);
    r = 32'(row_pos);
    // line stores: middle row moves up, new pixel goes into the middle
    up  = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = px;
    if (c >= cols_written_once) cols_written_once = c + 1;
    else if (c >= cols_written_twice) cols_written_twice = c + 1;
    // shift the window one column left and load the new column on the right
    for (k = 0; k < 3; k++) begin
      win[k*3]     = win[k*3 + 1];
      win[k*3 + 1] = win[k*3 + 2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;
    row_done   = (c >= w - 1);
    frame_done = row_done && (r >= h - 1);
    res   = '0;
    emits = (c >= 2) && (r >= 2);
    if (emits) begin
      ctr = win[4];
      // bit order: SE S SW W NW N NE E
      res.pattern_code = {win[8] >= ctr, win[7] >= ctr, win[6] >= ctr, win[3] >= ctr,
                          win[0] >= ctr, win[1] >= ctr, win[2] >= ctr, win[5] >= ctr};
      res.center_col   = COL_W'(c - 1);
      res.center_row   = ROW_W'(r - 1);
      res.frame_last   = frame_done;
    end
    if (row_done) begin
      col_pos = '0;
      row_pos = frame_done ? '0 : ROW_W'(r + 1);
    end else begin
      col_pos = COL_W'(c + 1);
    end
    return emits;
  endfunction

  function automatic logic [PIXEL_W-1:0] draw_pixel(input texture_e tex,
                                                    input logic [PIXEL_W-1:0] base);
    case (tex)
      TEX_TIES:    return base + PIXEL_W'($urandom_range(3));
      TEX_EXTREME: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      TEX_FLAT:    return ($urandom_range(3) == 0) ? PIXEL_W'($urandom_range(255)) : base;
      default:     return PIXEL_W'($urandom_range(255));
    endcase
  endfunction

  // one line per mismatch; printing stops after a while, counting does not
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_result(input lbp_result_t got);
    lbp_result_t want;
    if (expected_patterns.size() == 0) begin
      report_mismatch("result word with none pending, pattern_code", got.pattern_code, 0);
      return;
    end
    want = expected_patterns.pop_front();
    if (got.pattern_code !== want.pattern_code)
      report_mismatch("pattern_code", got.pattern_code, want.pattern_code);
    if (got.center_col !== want.center_col)
      report_mismatch("center_col", got.center_col, want.center_col);
    if (got.center_row !== want.center_row)
      report_mismatch("center_row", got.center_row, want.center_row);
    if (got.frame_last !== want.frame_last)
      report_mismatch("frame_last", got.frame_last, want.frame_last);
  endtask

  // stop sending, wait for every pending word, then let the pipeline drain
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (expected_patterns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == REG_IMAGE_WIDTH) width_reg = value[IMG_W_BITS-1:0];
    else height_reg = value;
  endtask

  // offer one pixel word, with random idle cycles ahead of it outside steady phases
  task automatic send_pixel(input logic [PIXEL_W-1:0] px, input bit typed,
                            input lbp_result_t typed_want);
    lbp_result_t predicted;
    bit          emits;
    while (!steady && $urandom_range(99) < 15) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    @(posedge clk);
    while (pix_ch.ready !== 1'b1) @(posedge clk);
    emits = lbp_advance(px, predicted);
    if (typed) expected_patterns = {expected_patterns, typed_want};
    else if (emits) expected_patterns = {expected_patterns, predicted};
  endtask

  // end the current frame early through the minimum size, then run up to its end
  task automatic to_frame_start();
    if (col_pos != 0 || row_pos != 0) begin
      write_reg(REG_IMAGE_WIDTH, '0);
      write_reg(REG_IMAGE_HEIGHT, '0);
      while (col_pos != 0 || row_pos != 0)
        send_pixel(draw_pixel(TEX_NOISE, 8'h00), 1'b0, NO_WORD);
    end
  endtask

  // receiver: checks accepted words, random stalls, a long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_result(res_ch.data);
        if (hold_left > 0) begin
          hold_left--;
          res_ch.ready <= 1'b0;
        end else if (holds_taken != hold_requests) begin
          holds_taken++;
          hold_left = HOLD_CYCLES;
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= steady || ($urandom_range(99) >= 15);
        end
      end
    end
  end

  // watchdog: too long without a word moving on either channel
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin : pixel_source
    int unsigned           random_sent, phase_no, n_items;
    logic [IMG_W_BITS-1:0] w_raw;
    logic [IMG_H_BITS-1:0] h_raw;
    texture_e              tex;
    logic [PIXEL_W-1:0]    base;
    random_sent = 0;
    phase_no    = 0;
    foreach (upper_line[k]) begin
      upper_line[k]  = '0;
      middle_line[k] = '0;
    end
    foreach (win[k]) win[k] = '0;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_IMAGE_WIDTH;
    cfg_data     <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_WRITE)
        write_reg(directed_steps[i].index, directed_steps[i].value);
      else
        send_pixel(directed_steps[i].value[PIXEL_W-1:0], directed_steps[i].typed,
                   directed_steps[i].want);
    end

    // random phases: in most, a new width, height or both (often mid-frame), then a burst of textured pixels
    while (random_sent < RANDOM_ITEMS) begin
      phase_no++;
      steady = (phase_no >= 6 && phase_no < 14);
      case ($urandom_range(19))
        0:       w_raw = IMG_W_BITS'($urandom_range(2));
        1:       w_raw = IMG_W_BITS'($urandom_range(2047, 17));
        2, 3:    w_raw = IMG_W_BITS'($urandom_range(64, 17));
        default: w_raw = IMG_W_BITS'($urandom_range(16, 3));
      endcase
      // mid-frame, stay within columns both line stores already hold
      if ((col_pos != 0 || row_pos != 0) && span_cols(w_raw) > cols_written_twice)
        w_raw = IMG_W_BITS'(cols_written_twice);
      case ($urandom_range(9))
        0:       h_raw = IMG_H_BITS'($urandom_range(2));
        1:       h_raw = IMG_H_BITS'($urandom_range(8191, 11));
        default: h_raw = IMG_H_BITS'($urandom_range(10, 3));
      endcase
      case ($urandom_range(3))
        0: write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_raw));
        1: write_reg(REG_IMAGE_HEIGHT, h_raw);
        2: begin
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_raw));
          write_reg(REG_IMAGE_HEIGHT, h_raw);
        end
        default: ;
      endcase
      // receiver holds off while the sender keeps offering, so the input stalls
      if (phase_no == 6) hold_requests++;
      tex     = texture_e'($urandom_range(3));
      base    = PIXEL_W'($urandom_range(255));
      n_items = $urandom_range(120, 20);
      repeat (n_items) send_pixel(draw_pixel(tex, base), 1'b0, NO_WORD);
      random_sent += n_items;
    end
    steady = 1'b0;

    // widest row: a width above range gives 1024 columns, short rows then end the frame
    to_frame_start();
    write_reg(REG_IMAGE_WIDTH, 13'd2047);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    repeat (MAX_WIDTH_DEF)
      send_pixel(draw_pixel(texture_e'($urandom_range(3)), 8'h80), 1'b0, NO_WORD);
    to_frame_start();

    settle();
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> local_binary_pattern_3x3_unit.f
rtl/core/lbp_pkg.sv
rtl/core/lbp_pixel_if.sv
rtl/core/lbp_result_if.sv
rtl/core/lbp_ram.sv
rtl/core/local_binary_pattern_3x3_unit.sv
tb/tb_local_binary_pattern_3x3_unit.sv
